// ----- rtl/assert_macros.svh -----
// Assertion macros for the replay window RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SRW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRW_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SRW_ASSERT(label, clk, rst_n, prop, msg)
`define SRW_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/srw_pkg.sv -----
// Types, constants and op codes for the sequence replay window.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package srw_pkg;

  localparam int SEQ_W       = 64;
  localparam int MAP_W       = 64;
  localparam int SHIFT_W     = 6;
  localparam int ACK_W       = 32;
  localparam int OP_W        = 2;
  localparam int WINDOW      = 64;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_FIELD_W = 1 + 1 + SEQ_W + ACK_W + SEQ_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SEQ_W-1:0] seq;
  } item_t;

  typedef struct packed {
    logic [SEQ_W-1:0] first_seq;
    logic [ACK_W-1:0] ack_window;
    logic [SEQ_W-1:0] highest_seq;
    logic             any_seen;
    logic             admitted;
  } result_t;

endpackage

// ----- rtl/srw_in_stage.sv -----
// Input register of the replay window: holds one transaction until it advances.
// Depends on srw_pkg.
`timescale 1ns / 1ps
module srw_in_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [srw_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [srw_pkg::OP_W-1:0]            in_tuser,
  input  logic                                advance,
  output logic                                item_valid,
  output srw_pkg::item_t                      item
);

  logic           valid_r;
  logic           valid_nxt;
  srw_pkg::item_t item_r;
  logic           load;

  assign in_tready = !valid_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.op  <= in_tuser;
      item_r.seq <= in_tdata[srw_pkg::SEQ_W-1:0];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- rtl/srw_window.sv -----
// Window state with combinational admission check and registered update.
// Depends on srw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srw_window (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  srw_pkg::item_t   item,
  output srw_pkg::result_t result
);

  logic                      seen_r, seen_nxt;
  logic [srw_pkg::SEQ_W-1:0] top_r, top_nxt;
  logic [srw_pkg::MAP_W-1:0] bitmap_r, bitmap_nxt;
  logic [srw_pkg::SEQ_W-1:0] base_r, base_nxt;

  logic                      is_newer;
  logic [srw_pkg::SEQ_W-1:0] ahead;
  logic [srw_pkg::SEQ_W-1:0] behind;
  logic                      in_window;
  logic                      ok;
  logic [srw_pkg::MAP_W-1:0] shifted;

  assign is_newer  = item.seq > top_r;
  assign ahead     = item.seq - top_r;
  assign behind    = top_r - item.seq;
  assign in_window = (behind < srw_pkg::SEQ_W'(srw_pkg::WINDOW)) &&
                     (behind[srw_pkg::SEQ_W-1:srw_pkg::SHIFT_W] == '0);
  assign shifted   = (ahead[srw_pkg::SEQ_W-1:srw_pkg::SHIFT_W] != '0) ? '0 :
                     (bitmap_r << ahead[srw_pkg::SHIFT_W-1:0]);

  always_comb begin
    seen_nxt   = seen_r;
    top_nxt    = top_r;
    bitmap_nxt = bitmap_r;
    base_nxt   = base_r;
    ok         = 1'b0;
    if (item.op == srw_pkg::OP_CLEAR) begin
      seen_nxt   = 1'b0;
      top_nxt    = '0;
      bitmap_nxt = '0;
      base_nxt   = '0;
    end else begin
      ok = !seen_r || is_newer ||
           (in_window && !bitmap_r[behind[srw_pkg::SHIFT_W-1:0]]);
      if (item.op == srw_pkg::OP_ACCEPT && ok) begin
        if (!seen_r) begin
          seen_nxt   = 1'b1;
          top_nxt    = item.seq;
          base_nxt   = item.seq;
          bitmap_nxt = srw_pkg::MAP_W'(1);
        end else if (is_newer) begin
          top_nxt    = item.seq;
          bitmap_nxt = shifted | srw_pkg::MAP_W'(1);
        end else begin
          bitmap_nxt[behind[srw_pkg::SHIFT_W-1:0]] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= 1'b0;
      top_r    <= '0;
      bitmap_r <= '0;
      base_r   <= '0;
    end else if (fire) begin
      seen_r   <= seen_nxt;
      top_r    <= top_nxt;
      bitmap_r <= bitmap_nxt;
      base_r   <= base_nxt;
    end
  end

  assign result.admitted    = ok;
  assign result.any_seen    = seen_nxt;
  assign result.highest_seq = top_nxt;
  assign result.ack_window  = bitmap_nxt[srw_pkg::ACK_W:1];
  assign result.first_seq   = base_nxt;

  `SRW_ASSERT(a_clear_empties, clk, rst_n, fire && item.op == srw_pkg::OP_CLEAR |=> !seen_r && bitmap_r == '0, "clear left window state")
  `SRW_ASSERT(a_empty_map, clk, rst_n, !seen_r |-> bitmap_r == '0, "bitmap set while window empty")
  `SRW_ASSERT(a_top_marked, clk, rst_n, seen_r |-> bitmap_r[0], "highest sequence not marked")
  `SRW_ASSERT(a_top_monotonic, clk, rst_n, fire && item.op != srw_pkg::OP_CLEAR && seen_r |=> top_r >= $past(top_r), "highest sequence went back")
  `SRW_ASSERT(a_idle_holds, clk, rst_n, !fire |=> $stable(top_r) && $stable(bitmap_r) && $stable(seen_r), "window changed without a transaction")

endmodule

// ----- rtl/sequence_replay_window_core.sv -----
// Top level of the anti-replay sliding window for 64-bit sequence numbers.
// Depends on srw_pkg, srw_in_stage and srw_window.
//
// Channel | Direction | Carries
// in_     | slave     | tuser: op[1:0]; tdata: seq[63:0]
// out_    | master    | tdata: admitted, any_seen, highest_seq, ack_window, first_seq, pad
//
// One transaction per cycle unless stalled; it passes the input, then the output register.
// The window registers are read and written in the cycle a transaction leaves
// the input register, so consecutive transactions see each other's updates.
// A stalled output holds both stages; the input register still fills while empty.
// Synchronous active-low reset empties the window and both stages.
`timescale 1ns / 1ps
module sequence_replay_window_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [srw_pkg::IN_TDATA_W-1:0]     in_tdata,   // seq[63:0]
  input  logic [srw_pkg::OP_W-1:0]           in_tuser,   // op[1:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [srw_pkg::OUT_TDATA_W-1:0]    out_tdata   // admitted, any_seen,
                                                         // highest_seq, ack_window,
                                                         // first_seq, zero pad
);

  logic             advance;
  logic             item_valid;
  logic             fire;
  srw_pkg::item_t   item;
  srw_pkg::result_t result;

  logic                              out_valid_r, out_valid_nxt;
  logic [srw_pkg::OUT_TDATA_W-1:0]   out_data_r;

  assign advance = !out_valid_r || out_tready;
  assign fire    = item_valid && advance;

  srw_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  srw_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {{srw_pkg::OUT_PAD_W{1'b0}}, result};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
